FILE: src/ihc_pkg.sv
// ----------------------------------------------------------------------------
// ihc_pkg
// types and constants shared by the inode handle cache modules
// ----------------------------------------------------------------------------
package ihc_pkg;

    localparam int IDX_W = 10;
    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // inodes per disk block, a power of two
    localparam int INODES_PER_BLOCK = 8;
    localparam int OFS_W            = $clog2(INODES_PER_BLOCK);

    localparam logic FN_GET = 1'b0;
    localparam logic FN_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_PUT_FREE = 2'd2
    } t_status;

    typedef struct packed {
        logic        func;
        logic [7:0]  device_id;
        logic [31:0] inode_number;
        logic [5:0]  slot_index;
        logic        mark_dirty;
    } t_req;

    typedef struct packed {
        logic [5:0]  slot_out;
        logic        hit;
        logic [1:0]  status;
        logic        need_read;
        logic        need_write_back;
        logic [31:0] disk_block;
        logic [2:0]  block_offset;
        logic [15:0] ref_count_out;
    } t_res;

    // search token moving down the cell row
    typedef struct packed {
        logic             valid;
        logic             func;
        logic             mark;
        logic [7:0]       dev;
        logic [31:0]      ino;
        logic [5:0]       slot;
        logic             found;
        logic [IDX_W-1:0] found_idx;
        logic [CNT_W-1:0] found_cnt;
        logic             found_dirty;
        logic [31:0]      found_ino;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
    } t_tok;

    // update broadcast to all cells at the end of an operation
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             wr_tag;
        logic [CNT_W-1:0] cnt;
        logic             dirty;
        logic [7:0]       dev;
        logic [31:0]      ino;
    } t_cmd;

endpackage

FILE: src/ihc_req_if.sv
// ----------------------------------------------------------------------------
// ihc_req_if
// request channel: valid, ready and one get or put item
// ----------------------------------------------------------------------------
interface ihc_req_if import ihc_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/ihc_res_if.sv
// ----------------------------------------------------------------------------
// ihc_res_if
// result channel: valid, ready and one result item
// ----------------------------------------------------------------------------
interface ihc_res_if import ihc_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/inode_handle_cache_core.sv
// ----------------------------------------------------------------------------
// inode_handle_cache_core
// reference counted inode handle table with get/put requests
//
//   channel   dir   payload
//   i_req     in    func, device_id, inode_number, slot_index, mark_dirty
//   o_res     out   slot, hit, status, read/write-back flags, location, count
//   i_cfg_*   in    table start block
//
// one item at a time: a search token walks the SLOTS cells, one per cycle,
// and the location is a registered shift and mask of inode - 1.
// the result is registered once the search token has left the last cell, and
// the next request is taken when the block is back in idle, for a get or a put.
// synchronous reset frees every slot at once. a stalled result holds the
// block before its update, and a new request is taken once the last is done.
// ----------------------------------------------------------------------------
module inode_handle_cache_core import ihc_pkg::*; #(
    parameter int SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ihc_req_if.sink     i_req,
    ihc_res_if.source   o_res,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} t_state;

    t_state      r_state;
    t_tok        r_end;
    t_res        r_out;
    logic        r_out_valid;
    logic [31:0] r_table_start;

    t_tok        w_tok [SLOTS+1];
    t_cmd        w_cmd;
    t_res        w_res;
    logic        w_accept;
    logic        w_put_ok_scan;
    logic        w_put_ok;
    logic        w_fin_go;
    logic        w_div_start;
    logic [31:0] w_dividend;
    logic [31:0] w_quot;
    logic [OFS_W-1:0] w_rem;
    logic [CNT_W-1:0] w_dec;
    logic        w_dirty_any;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    always_comb begin
        w_tok[0]             = '0;
        w_tok[0].valid       = w_accept;
        w_tok[0].func        = i_req.data.func;
        w_tok[0].mark        = i_req.data.mark_dirty;
        w_tok[0].dev         = i_req.data.device_id;
        w_tok[0].ino         = i_req.data.inode_number;
        w_tok[0].slot        = i_req.data.slot_index;
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        ihc_cell #(.CELL_IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .i_cmd   (w_cmd)
        );
    end

    assign w_put_ok_scan = w_tok[SLOTS].found && (w_tok[SLOTS].found_cnt != '0);
    assign w_div_start   = (w_accept && i_req.data.func == FN_GET)
                        || (r_state == S_SCAN && w_tok[SLOTS].valid
                            && w_tok[SLOTS].func == FN_PUT && w_put_ok_scan);
    assign w_dividend    = w_accept ? (i_req.data.inode_number - 32'd1)
                                    : (w_tok[SLOTS].found_ino - 32'd1);

    ihc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign w_fin_go    = (r_state == S_FIN) && (!r_out_valid || o_res.ready);
    assign w_put_ok    = r_end.found && (r_end.found_cnt != '0);
    assign w_dec       = r_end.found_cnt - 16'd1;
    assign w_dirty_any = r_end.found_dirty || r_end.mark;

    always_comb begin
        w_res              = '0;
        w_cmd              = '0;
        w_cmd.dev          = r_end.dev;
        w_cmd.ino          = r_end.ino;
        w_res.disk_block   = w_quot + r_table_start;
        w_res.block_offset = w_rem;
        if (r_end.func == FN_GET) begin
            if (r_end.found) begin
                w_res.slot_out      = r_end.found_idx[5:0];
                w_res.hit           = 1'b1;
                w_res.ref_count_out = (r_end.found_cnt == CNT_MAX) ? CNT_MAX
                                    : r_end.found_cnt + 16'd1;
                w_cmd.en            = w_fin_go;
                w_cmd.idx           = r_end.found_idx;
                w_cmd.cnt           = w_res.ref_count_out;
                w_cmd.dirty         = r_end.found_dirty;
            end else if (r_end.free_found) begin
                w_res.slot_out      = r_end.free_idx[5:0];
                w_res.need_read     = 1'b1;
                w_res.ref_count_out = 16'd1;
                w_cmd.en            = w_fin_go;
                w_cmd.idx           = r_end.free_idx;
                w_cmd.wr_tag        = 1'b1;
                w_cmd.cnt           = 16'd1;
                w_cmd.dirty         = 1'b0;
            end else begin
                w_res.status = ST_FULL;
            end
        end else begin
            w_res.slot_out = r_end.slot;
            if (w_put_ok) begin
                w_res.ref_count_out   = w_dec;
                w_res.need_write_back = (w_dec == '0) && w_dirty_any;
                w_cmd.en              = w_fin_go;
                w_cmd.idx             = r_end.found_idx;
                w_cmd.cnt             = w_dec;
                w_cmd.dirty           = w_dirty_any && (w_dec != '0);
            end else begin
                w_res.status       = ST_PUT_FREE;
                w_res.disk_block   = '0;
                w_res.block_offset = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_table_start <= '0;
        end else begin
            if (i_cfg_we) begin
                r_table_start <= i_cfg_wdata;
            end
            if (w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_tok[SLOTS].valid) begin
                        r_end   <= w_tok[SLOTS];
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_fin_go) begin
                        r_out   <= w_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

FILE: src/ihc_cell.sv
// ----------------------------------------------------------------------------
// ihc_cell
// one handle slot: count, dirty mark and tags, plus one stage of the token row
// ----------------------------------------------------------------------------
module ihc_cell import ihc_pkg::*; #(
    parameter int CELL_IDX = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_tok i_tok,
    output t_tok o_tok,
    input  t_cmd i_cmd
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [CNT_W-1:0] r_cnt;
    logic             r_dirty;
    logic [7:0]       r_dev;
    logic [31:0]      r_ino;
    t_tok             r_tok;
    t_tok             n_tok;
    logic             w_live;
    logic             w_slot_hit;

    assign w_live     = (r_cnt != '0);
    assign w_slot_hit = (IDX_W'(i_tok.slot) == MY_IDX);

    always_comb begin
        n_tok = i_tok;
        if (i_tok.func == FN_GET) begin
            if (!i_tok.found && w_live && r_dev == i_tok.dev && r_ino == i_tok.ino) begin
                n_tok.found       = 1'b1;
                n_tok.found_idx   = MY_IDX;
                n_tok.found_cnt   = r_cnt;
                n_tok.found_dirty = r_dirty;
                n_tok.found_ino   = r_ino;
            end
            if (!i_tok.free_found && !w_live) begin
                n_tok.free_found = 1'b1;
                n_tok.free_idx   = MY_IDX;
            end
        end else if (w_slot_hit) begin
            n_tok.found       = 1'b1;
            n_tok.found_idx   = MY_IDX;
            n_tok.found_cnt   = r_cnt;
            n_tok.found_dirty = r_dirty;
            n_tok.found_ino   = r_ino;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= '0;
            r_cnt   <= '0;
            r_dirty <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_cmd.en && i_cmd.idx == MY_IDX) begin
                r_cnt   <= i_cmd.cnt;
                r_dirty <= i_cmd.dirty;
                if (i_cmd.wr_tag) begin
                    r_dev <= i_cmd.dev;
                    r_ino <= i_cmd.ino;
                end
            end
        end
    end

    assign o_tok = r_tok;

endmodule

FILE: src/ihc_div.sv
// ----------------------------------------------------------------------------
// ihc_div
// registered split of a 32-bit value into block and offset by the
// power-of-two inodes per block
// ----------------------------------------------------------------------------
module ihc_div import ihc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [31:0]      i_dividend,
    output logic [31:0]      o_quot,
    output logic [OFS_W-1:0] o_rem
);

    logic [31:0]      r_q;
    logic [OFS_W-1:0] r_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
            r_r <= '0;
        end else if (i_start) begin
            r_q <= i_dividend >> OFS_W;
            r_r <= i_dividend[OFS_W-1:0];
        end
    end

    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule
